[rtl/core/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Token codes, status codes, the stack cell command type and defaults.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int DefaultStackDepth = 64;
   localparam int ValueWidth        = 32;
   localparam int FuncWidth         = 3;
   localparam int OperandWidth      = 30;
   localparam int StatusWidth       = 2;

   localparam logic [FuncWidth-1:0] FUNC_OPERAND  = 3'd0;
   localparam logic [FuncWidth-1:0] FUNC_ADD      = 3'd1;
   localparam logic [FuncWidth-1:0] FUNC_SUB      = 3'd2;
   localparam logic [FuncWidth-1:0] FUNC_MUL      = 3'd3;
   localparam logic [FuncWidth-1:0] FUNC_DIV      = 3'd4;
   localparam logic [FuncWidth-1:0] FUNC_POW      = 3'd5;
   localparam logic [FuncWidth-1:0] FUNC_UNKNOWN  = 3'd6;
   localparam logic [FuncWidth-1:0] FUNC_RESERVED = 3'd7;

   localparam logic [StatusWidth-1:0] STATUS_OK      = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_COUNT   = 2'd2;

   // Command that every cell of the stack sees in the same cycle.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_cmd_type;

endpackage

[rtl/core/pse_cell.sv]
// ----------------------------------------------------------------------------
// pse_cell: one entry of the shift stack
// On a push it takes its upper neighbor's value, on a pop its lower one's.
// ----------------------------------------------------------------------------
module pse_cell (
   input  logic                       clock,
   input  pse_pkg::cell_cmd_type      cmd,
   input  logic [pse_pkg::ValueWidth-1:0] from_above,
   input  logic [pse_pkg::ValueWidth-1:0] from_below,
   output logic [pse_pkg::ValueWidth-1:0] value
);
   import pse_pkg::*;

   logic [ValueWidth-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.push) begin
         value_in = from_above;
      end else if (cmd.pop) begin
         value_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

[rtl/core/pse_alu.sv]
// ----------------------------------------------------------------------------
// pse_alu: multi-cycle arithmetic unit
// Add and subtract straight from idle; multiply over registered steps; restoring
// division one bit a cycle; power by square-and-multiply, one step a cycle.
// ----------------------------------------------------------------------------
module pse_alu (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pse_pkg::FuncWidth-1:0]  func,
   input  logic [pse_pkg::ValueWidth-1:0] b_value,
   input  logic [pse_pkg::ValueWidth-1:0] a_value,
   output logic                           done,
   output logic [pse_pkg::ValueWidth-1:0] result
);
   import pse_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_POW  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [5:0]            step_ff, step_in;
   logic [ValueWidth-1:0] acc_ff, acc_in;     // quotient or power accumulator
   logic [ValueWidth-1:0] rem_ff, rem_in;     // remainder or squared base
   logic [ValueWidth-1:0] opa_ff, opa_in;     // divisor magnitude or exponent
   logic [ValueWidth-1:0] res_ff, res_in;
   logic                  neg_ff, neg_in;
   logic [ValueWidth-1:0] mag_b, mag_a;
   logic [ValueWidth:0]   trial;

   always_comb begin
      mag_b = b_value[ValueWidth-1] ? (~b_value + 1'b1) : b_value;
      mag_a = a_value[ValueWidth-1] ? (~a_value + 1'b1) : a_value;
      trial = {rem_ff, acc_ff[ValueWidth-1]} - {1'b0, opa_ff};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      opa_in   = opa_ff;
      res_in   = res_ff;
      neg_in   = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DONE;
               case (func)
                  FUNC_ADD: res_in = b_value + a_value;
                  FUNC_SUB: res_in = b_value - a_value;
                  FUNC_MUL: begin
                     acc_in   = b_value;
                     opa_in   = a_value;
                     state_in = ST_MUL;
                  end
                  FUNC_DIV: begin
                     if (a_value == '0) begin
                        res_in = '0;
                     end else begin
                        acc_in   = mag_b;
                        rem_in   = '0;
                        opa_in   = mag_a;
                        neg_in   = b_value[ValueWidth-1] ^ a_value[ValueWidth-1];
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  FUNC_POW: begin
                     if (a_value[ValueWidth-1]) begin
                        if (b_value == 32'd1) begin
                           res_in = 32'd1;
                        end else if (b_value == '1) begin
                           res_in = a_value[0] ? '1 : 32'd1;
                        end else begin
                           res_in = '0;
                        end
                     end else begin
                        acc_in   = 32'd1;
                        rem_in   = b_value;
                        opa_in   = a_value;
                        step_in  = '0;
                        state_in = ST_POW;
                     end
                  end
                  default: res_in = '0;
               endcase
            end
         end
         ST_MUL: begin
            res_in   = acc_ff * opa_ff;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (!trial[ValueWidth]) begin
               rem_in = trial[ValueWidth-1:0];
               acc_in = {acc_ff[ValueWidth-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ValueWidth-2:0], acc_ff[ValueWidth-1]};
               acc_in = {acc_ff[ValueWidth-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd31) begin
               state_in = ST_MUL;
               opa_in   = 32'd1;
               acc_in   = neg_ff ? (~acc_in + 1'b1) : acc_in;
            end
         end
         ST_POW: begin
            // Up to two products per step: the accumulator, when the exponent bit is set, and the squared base.
            if (opa_ff[0]) begin
               acc_in = acc_ff * rem_ff;
            end
            rem_in  = rem_ff * rem_ff;
            opa_in  = {1'b0, opa_ff[ValueWidth-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd30) begin
               state_in = ST_MUL;
               opa_in   = 32'd1;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      opa_ff  <= opa_in;
      res_ff  <= res_in;
      neg_ff  <= neg_in;
   end

   assign done   = (state_ff == ST_DONE);
   assign result = res_ff;
endmodule

[rtl/core/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: postfix expression evaluator
// Token words in, one result word per expression on its last token.
// ----------------------------------------------------------------------------
// Tokens enter one at a time. The stack is a chain of cells that all shift
// toward the bottom on a push and toward the top on a pop, so the top two
// values always sit in the first two cells. An operand token passes the push
// and end states, and an unknown or ignored token only the end state. An
// operator token passes the pop state once per operand, the arithmetic unit,
// the push and the end state; a divide by zero or a power with a negative
// exponent skips the 32-step divide and 31-step square-and-multiply loops in
// the arithmetic unit. A result word waits in an output register while the
// next token is accepted; a last token whose word finds that register still
// full waits until the earlier word is taken.
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::DefaultStackDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operand_value[29:0], zero fill
   input  logic [2:0]  req_tuser,   // func[2:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result_value[31:0], status[33:32],
                                    // underflow_seen[34], overflow_seen[35]
);
   import pse_pkg::*;

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(STACK_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POP  = 3'd1;
   localparam logic [2:0] ST_ALU  = 3'd2;
   localparam logic [2:0] ST_PUSH = 3'd3;
   localparam logic [2:0] ST_END  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  unk_ff, unk_in, und_ff, und_in, ovf_ff, ovf_in;
   logic [FuncWidth-1:0]  func_ff, func_in;
   logic                  last_ff, last_in;
   logic [ValueWidth-1:0] a_ff, a_in, b_ff, b_in, push_ff, push_in;
   logic                  ov_ff, ov_in;
   logic [39:0]           od_ff, od_in;
   logic                  alu_start, alu_done;
   logic [ValueWidth-1:0] alu_result;
   cell_cmd_type          cmd;
   logic [ValueWidth-1:0] cell_val [STACK_DEPTH];
   logic [FuncWidth-1:0]  in_func;

   assign in_func    = req_tuser;
   assign req_tready = (state_ff == ST_IDLE);
   // The arithmetic unit is idle only in the first cycle of ST_ALU.
   assign alu_start  = (state_ff == ST_ALU);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unk_in = unk_ff; und_in = und_ff; ovf_in = ovf_ff;
      func_in = func_ff; last_in = last_ff;
      a_in = a_ff; b_in = b_ff; push_in = push_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in = in_func;
               last_in = req_tlast;
               push_in = {2'b00, req_tdata[29:0]};
               if (unk_ff) begin
                  state_in = ST_END;
               end else if (in_func == FUNC_OPERAND) begin
                  state_in = ST_PUSH;
               end else if (in_func <= FUNC_POW) begin
                  state_in = ST_POP;
                  a_in     = '0;
                  b_in     = '0;
                  push_in  = '0;
               end else begin
                  unk_in   = 1'b1;
                  state_in = ST_END;
               end
            end
         end
         ST_POP: begin
            // Pop a from the top cell, then b on the second pass.
            if (count_ff == '0) begin
               und_in = 1'b1;
            end else begin
               cmd.pop  = 1'b1;
               count_in = count_ff - 1'b1;
            end
            a_in = b_ff;
            b_in = (count_ff == '0) ? '0 : cell_val[0];
            func_in = func_ff;
            if (push_ff[31]) begin
               // Second pop done: the operand order is now a then b.
               state_in = ST_ALU;
               a_in     = b_ff;
            end
            push_in[31] = 1'b1;
         end
         ST_ALU: begin
            if (alu_done) begin
               push_in  = alu_result;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (count_ff == FullCount) begin
               ovf_in = 1'b1;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = ST_END;
         end
         ST_END: begin
            state_in = ST_IDLE;
            if (last_ff) begin
               if (ov_ff && !rsp_tready) begin
                  state_in = ST_END;
               end else begin
                  ov_in = 1'b1;
                  od_in = '0;
                  if (unk_ff) begin
                     od_in[33:32] = STATUS_UNKNOWN;
                  end else if (count_ff == CountWidth'(1)) begin
                     od_in[31:0]  = cell_val[0];
                     od_in[33:32] = STATUS_OK;
                  end else begin
                     od_in[33:32] = STATUS_COUNT;
                  end
                  od_in[34] = und_ff;
                  od_in[35] = ovf_ff;
                  count_in = '0; unk_in = 1'b0; und_in = 1'b0; ovf_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         unk_ff <= 1'b0; und_ff <= 1'b0; ovf_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         unk_ff <= unk_in; und_ff <= und_in; ovf_ff <= ovf_in;
         ov_ff <= ov_in;
      end
      func_ff <= func_in;
      last_ff <= last_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      push_ff <= push_in;
      od_ff   <= od_in;
   end

   genvar g;
   generate
      for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
         logic [ValueWidth-1:0] above, below;
         if (g == 0) begin : g_top
            assign above = push_ff;
         end else begin : g_mid
            assign above = cell_val[g-1];
         end
         if (g == STACK_DEPTH - 1) begin : g_bot
            assign below = '0;
         end else begin : g_up
            assign below = cell_val[g+1];
         end
         pse_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .value      (cell_val[g])
         );
      end
   endgenerate

   pse_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .start   (alu_start),
      .func    (func_ff),
      .b_value (b_ff),
      .a_value (a_ff),
      .done    (alu_done),
      .result  (alu_result)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
endmodule

[rtl/core/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker: port-level assertions of the postfix stack evaluator
// Watches the handshake ports and the result word.
// ----------------------------------------------------------------------------
module pse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import pse_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] <= STATUS_COUNT)
      else $error("illegal status code");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != STATUS_OK |-> rsp_tdata[31:0] == '0)
      else $error("nonzero value with error status");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("token accepted while busy");
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the postfix stack evaluator
// Drives random and directed token words, predicts each expression result
// with a behavioral stack model, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
   import pse_pkg::*;

   class expr_scoreboard;
      logic [31:0] stack_q[$];
      bit          unk_err, under_f, over_f;
      logic [35:0] pending_results[$];
      int          error_count;
      int          depth;

      function new(int d);
         depth = d;
      endfunction

      function logic [31:0] pop_one();
         if (stack_q.size() == 0) begin
            under_f = 1;
            return 32'd0;
         end
         return stack_q.pop_back();
      endfunction

      function void push_one(logic [31:0] v);
         if (stack_q.size() >= depth) over_f = 1;
         else stack_q.push_back(v);
      endfunction

      function logic [31:0] divide_trunc(logic [31:0] b, logic [31:0] a);
         logic [31:0] mb, ma, q;
         if (a == 0) return 32'd0;
         mb = b[31] ? -b : b;
         ma = a[31] ? -a : a;
         q = mb / ma;
         return (b[31] ^ a[31]) ? -q : q;
      endfunction

      function logic [31:0] power_wrap(logic [31:0] base, logic [31:0] ex);
         logic [31:0] acc;
         acc = 1;
         if (ex[31]) begin
            if (base == 1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
         end
         for (int i = 0; i < 31; i++) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex = ex >> 1;
         end
         return acc;
      endfunction

      function void note_token(logic [2:0] func, logic [29:0] opv, bit last);
         logic [31:0] a, b, r;
         logic [31:0] value;
         logic [1:0]  status;
         if (!unk_err) begin
            if (func == FUNC_OPERAND) begin
               push_one({2'b00, opv});
            end else if (func >= FUNC_ADD && func <= FUNC_POW) begin
               a = pop_one();
               b = pop_one();
               case (func)
                  FUNC_ADD: r = b + a;
                  FUNC_SUB: r = b - a;
                  FUNC_MUL: r = b * a;
                  FUNC_DIV: r = divide_trunc(b, a);
                  default:  r = power_wrap(b, a);
               endcase
               push_one(r);
            end else begin
               unk_err = 1;
            end
         end
         if (last) begin
            value = 0;
            if (unk_err) status = STATUS_UNKNOWN;
            else if (stack_q.size() == 1) begin
               status = STATUS_OK;
               value = stack_q[0];
            end else status = STATUS_COUNT;
            pending_results.push_back({over_f, under_f, status, value});
            stack_q.delete();
            unk_err = 0;
            under_f = 0;
            over_f = 0;
         end
      endfunction

      function void check_result(logic [39:0] data);
         logic [35:0] exp_w;
         if (pending_results.size() == 0) begin
            $error("result word with no expectation: %h", data);
            error_count++;
            return;
         end
         exp_w = pending_results.pop_front();
         if (data[31:0] !== exp_w[31:0]) begin
            $error("result_value expected %h actual %h", exp_w[31:0], data[31:0]);
            error_count++;
         end
         if (data[33:32] !== exp_w[33:32]) begin
            $error("status expected %0d actual %0d", exp_w[33:32], data[33:32]);
            error_count++;
         end
         if (data[34] !== exp_w[34]) begin
            $error("underflow_seen expected %0d actual %0d", exp_w[34], data[34]);
            error_count++;
         end
         if (data[35] !== exp_w[35]) begin
            $error("overflow_seen expected %0d actual %0d", exp_w[35], data[35]);
            error_count++;
         end
      endfunction
   endclass

   localparam int Depth = DefaultStackDepth;
   localparam int WatchLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   expr_scoreboard sb = new(Depth);
   bit  hold_rsp = 0;
   int  idle_cycles = 0;

   postfix_stack_evaluator #(.STACK_DEPTH(Depth)) DUT (.*);

   always #5 clock = ~clock;

   function int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // Presents one token word and holds it until accepted.
   task send_token(logic [2:0] func, logic [29:0] opv, bit last, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b00, opv};
      req_tuser <= func;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_token(func, opv, last);
      @(negedge clock);
   endtask

   task idle_sender();
      req_tvalid <= 0;
      @(negedge clock);
   endtask

   function logic [29:0] rand_opv();
      case ($urandom_range(0, 4))
         0: return 30'd0;
         1: return 30'($urandom_range(0, 9));
         2: return 30'd999999999;
         3: return 30'($urandom);
         default: return 30'($urandom_range(0, 1000));
      endcase
   endfunction

   function logic [2:0] rand_op();
      return 3'($urandom_range(1, 5));
   endfunction

   // A well-formed expression of n operands with random operators.
   task send_expression(int n, bit no_gap = 0);
      int pend;
      pend = 0;
      for (int i = 0; i < n; i++) begin
         send_token(FUNC_OPERAND, rand_opv(), (n == 1), no_gap);
         pend++;
         while (pend >= 2 && $urandom_range(0, 1)) begin
            pend--;
            send_token(rand_op(), 30'($urandom), (i == n - 1 && pend == 1), no_gap);
         end
      end
      while (pend > 1) begin
         pend--;
         send_token(rand_op(), 30'($urandom), (pend == 1), no_gap);
      end
   endtask

   // Receiver: random stalls, or a long hold when asked.
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int cnt, k, ops;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: each operator and the special cases.
      send_token(FUNC_OPERAND, 30'd999999999, 1);
      send_token(FUNC_OPERAND, 30'd7, 0);
      send_token(FUNC_OPERAND, 30'd3, 0);
      send_token(FUNC_SUB, 0, 0);
      send_token(FUNC_OPERAND, 30'd9, 0);
      send_token(FUNC_SUB, 0, 0);         // 4 - 9 gives a negative value
      send_token(FUNC_OPERAND, 30'd2, 0);
      send_token(FUNC_DIV, 0, 1);         // truncation toward zero
      send_token(FUNC_OPERAND, 30'd5, 0);
      send_token(FUNC_OPERAND, 30'd0, 0);
      send_token(FUNC_DIV, 0, 1);         // divide by zero
      send_token(FUNC_OPERAND, 30'd0, 0);
      send_token(FUNC_OPERAND, 30'd0, 0);
      send_token(FUNC_POW, 0, 1);         // zero to the zero
      send_token(FUNC_OPERAND, 30'd3, 0);
      send_token(FUNC_OPERAND, 30'd40, 0);
      send_token(FUNC_POW, 0, 0);
      send_token(FUNC_OPERAND, 30'd999999999, 0);
      send_token(FUNC_MUL, 0, 0);
      send_token(FUNC_OPERAND, 30'd1, 0);
      send_token(FUNC_ADD, 0, 1);
      send_token(FUNC_ADD, 0, 1);         // underflow on an empty stack
      send_token(FUNC_UNKNOWN, 30'h3FFF_FFFF, 0); // unknown operator, then ignored
      send_token(FUNC_OPERAND, 30'd1, 1);
      send_token(FUNC_RESERVED, 0, 1);
      send_token(FUNC_OPERAND, 30'd1, 0);
      send_token(FUNC_OPERAND, 30'd2, 1); // two values left

      // One divided by -1, and a negative exponent.
      send_token(FUNC_OPERAND, 30'd0, 0);
      send_token(FUNC_OPERAND, 30'd1, 0);
      send_token(FUNC_SUB, 0, 0);         // -1
      send_token(FUNC_OPERAND, 30'd1, 0);
      send_token(FUNC_OPERAND, 30'd31, 0);
      send_token(FUNC_POW, 0, 0);         // 1 to the 31st stays 1
      send_token(FUNC_OPERAND, 30'd0, 0);
      send_token(FUNC_OPERAND, 30'd1, 0);
      send_token(FUNC_SUB, 0, 0);
      send_token(FUNC_DIV, 0, 0);
      send_token(FUNC_POW, 0, 1);         // (-1) ^ (-1)

      // Fill past the depth: overflow.
      for (int i = 0; i < Depth + 2; i++) send_token(FUNC_OPERAND, rand_opv(), 0, 1);
      send_token(FUNC_OPERAND, 30'd1, 1, 1);

      // Sender pauses until every expected result has come.
      while (sb.pending_results.size() != 0) idle_sender();

      // Long receiver hold while the sender keeps offering words.
      hold_rsp = 1;
      for (int i = 0; i < 12; i++) send_expression(1, 1);

      cnt = 0;
      while (cnt < 630) begin
         k = $urandom_range(0, 19);
         if (k < 15) begin
            ops = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            send_expression(ops);
            cnt += 2 * ops - 1;
         end else begin
            send_token(3'($urandom_range(0, 7)), 30'($urandom), $urandom_range(0, 2) == 0);
            cnt++;
         end
      end
      send_token(FUNC_OPERAND, 30'd1, 1);
      req_tvalid <= 0;

      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (sb.error_count == 0 && sb.pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/pse_pkg.sv
rtl/core/pse_cell.sv
rtl/core/pse_alu.sv
rtl/core/postfix_stack_evaluator.sv
rtl/core/pse_checker.sv
tb/tb.sv
